>>> rtl/core/pqie_pkg.sv
// Package for the bounded max-priority queue: opcodes, status codes and the
// per-cell command struct. Used by pqie_cell and the top unit under rtl/core.
package pqie_pkg;

  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Broadcast to all cells in the cycle a request is carried out.
  typedef struct packed {
    logic ins;
    logic ext;
  } pq_cmd_t;

endpackage

>>> rtl/core/pqie_cell.sv
// One slot of the sorted chain: holds a priority and a tag, trades with its
// left and right neighbors. Depends on pqie_pkg.
module pqie_cell #(
  parameter int PRIORITY_BITS = 8,
  parameter int TAG_BITS      = 16
) (
  input  logic                     clk,
  input  pqie_pkg::pq_cmd_t        cmd,
  input  logic                     occupied,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [TAG_BITS-1:0]      new_tag,
  input  logic                     left_ahead,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [TAG_BITS-1:0]      left_tag,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [TAG_BITS-1:0]      right_tag,
  output logic                     ahead,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [TAG_BITS-1:0]      tag
);
  import pqie_pkg::*;

  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]      tag_r, tag_nxt;

  // New entry lands ahead of this slot: slot empty or strictly lower priority
  // (equal priority stays ahead, giving arrival order on ties).
  assign ahead = !occupied || (prio_r < new_prio);

  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (cmd.ins && ahead) begin
      if (left_ahead) begin
        prio_nxt = left_prio;
        tag_nxt  = left_tag;
      end else begin
        prio_nxt = new_prio;
        tag_nxt  = new_tag;
      end
    end else if (cmd.ext) begin
      prio_nxt = right_prio;
      tag_nxt  = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign prio = prio_r;
  assign tag  = tag_r;

endmodule

>>> rtl/core/pqie_out_stage.sv
// Output register with one skid entry, so a request can be taken while a
// result waits. Self-contained, no package needed.
module pqie_out_stage #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  logic             out_valid_r;
  logic [WIDTH-1:0] out_data_r;
  logic             skid_valid_r;
  logic [WIDTH-1:0] skid_data_r;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  // the pusher must not push while the skid entry is held; this block does not enforce it
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/priority_queue_insert_extract_max_unit.sv
// Bounded max-priority queue built as a sorted chain of cells, head at cell 0.
// Results are registered in the output stage. Throughput: one request per cycle
// while in_stall is low; every cell compares and shifts in parallel
// in that cycle, and a two-entry output stage keeps input open while a result waits.
// Reset: clears the entry count and output valids; cell contents are left as is.
module priority_queue_insert_extract_max_unit #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int TAG_BITS      = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [PRIORITY_BITS-1:0]       in_item_priority,
  input  logic [TAG_BITS-1:0]            in_item_tag,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pqie_pkg::STATUS_W-1:0]  out_status,
  output logic [PRIORITY_BITS-1:0]       out_priority,
  output logic [TAG_BITS-1:0]            out_tag,
  output logic [pqie_pkg::OCC_W-1:0]     out_occupancy
);
  import pqie_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int RES_W = STATUS_W + PRIORITY_BITS + TAG_BITS + OCC_W;

  logic [CW-1:0] count_r, count_nxt;
  logic          accept, is_full, is_empty;
  pq_cmd_t       cmd;
  logic [STATUS_W-1:0]      res_status;
  logic [PRIORITY_BITS-1:0] res_prio;
  logic [TAG_BITS-1:0]      res_tag;
  logic [RES_W-1:0]         res_data, out_data;
  logic                     stage_full;

  logic [CAPACITY-1:0]      ahead_v;
  logic [PRIORITY_BITS-1:0] prio_v [CAPACITY];
  logic [TAG_BITS-1:0]      tag_v  [CAPACITY];

  assign accept   = in_valid && !stage_full;
  assign in_stall = stage_full;
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign cmd.ins = accept && (in_opcode == OP_INSERT) && !is_full;
  assign cmd.ext = accept && (in_opcode == OP_EXTRACT) && !is_empty;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.ext) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     lb;
      logic [PRIORITY_BITS-1:0] lp, rp;
      logic [TAG_BITS-1:0]      lt, rt;
      if (i == 0) begin : g_head
        assign lb = 1'b0;
        assign lp = '0;
        assign lt = '0;
      end else begin : g_mid
        assign lb = ahead_v[i-1];
        assign lp = prio_v[i-1];
        assign lt = tag_v[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign rp = prio_v[i];
        assign rt = tag_v[i];
      end else begin : g_body
        assign rp = prio_v[i+1];
        assign rt = tag_v[i+1];
      end
      pqie_cell #(
        .PRIORITY_BITS(PRIORITY_BITS),
        .TAG_BITS     (TAG_BITS)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (count_r > CW'(i)),
        .new_prio   (in_item_priority),
        .new_tag    (in_item_tag),
        .left_ahead (lb),
        .left_prio  (lp),
        .left_tag   (lt),
        .right_prio (rp),
        .right_tag  (rt),
        .ahead      (ahead_v[i]),
        .prio       (prio_v[i]),
        .tag        (tag_v[i])
      );
    end
  endgenerate

  always_comb begin
    res_status = ST_OK;
    if (in_opcode == OP_INSERT && is_full) begin
      res_status = ST_FULL;
    end else if (in_opcode == OP_EXTRACT && is_empty) begin
      res_status = ST_EMPTY;
    end
  end

  assign res_prio = cmd.ext ? prio_v[0] : '0;
  assign res_tag  = cmd.ext ? tag_v[0]  : '0;
  assign res_data = {res_status, res_prio, res_tag, OCC_W'(count_nxt)};

  pqie_out_stage #(
    .WIDTH(RES_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(res_data),
    .full     (stage_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign {out_status, out_priority, out_tag, out_occupancy} = out_data;

endmodule
